[hw/rtl/linear_svm_softmax_classifier_unit_assert.svh]
// Assertion macros for the linear classifier unit.
// Used by the port checker; no other dependencies.
`ifndef LINEAR_SVM_SOFTMAX_CLASSIFIER_UNIT_ASSERT_SVH
`define LINEAR_SVM_SOFTMAX_CLASSIFIER_UNIT_ASSERT_SVH

// same-cycle implication
`define LSSC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lssc assertion failed");

// next-cycle implication
`define LSSC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lssc assertion failed");

`endif

[hw/rtl/lssc_pkg.sv]
// Package for the linear classifier unit: sizes, coefficient tables,
// sequencer states. No dependencies.
package lssc_pkg;

  localparam int FEATURE_COUNT_DEF = 12;
  localparam int CLASS_COUNT_DEF   = 4;
  localparam int ROM_CLASSES       = 4;
  localparam int ROM_FEATURES      = 12;

  // ln2 and the exp cutoff (16.0), both in Q32.32
  localparam logic [31:0] LN2_Q32   = 32'd2977044472;
  localparam logic [63:0] EXP_LIMIT = 64'd16 << 32;
  localparam logic [3:0]  SER_TERMS = 4'd13;

  // shared divider dividend width
  localparam int DIV_W = 40;

  localparam logic signed [31:0] WEIGHT_ROM [ROM_CLASSES][ROM_FEATURES] = '{
    '{32'sd2654, 32'sd201, -32'sd2500, 32'sd257, -32'sd296, -32'sd230, 32'sd896,
      -32'sd26690, -32'sd34128, -32'sd12904, -32'sd1554, 32'sd5803},
    '{32'sd35281, -32'sd12309, 32'sd36066, -32'sd14746, 32'sd3500, -32'sd418,
      -32'sd18163, 32'sd2109, 32'sd4411, -32'sd33974, -32'sd4595, -32'sd4787},
    '{-32'sd82782, 32'sd35594, -32'sd83571, 32'sd25812, -32'sd8352, 32'sd15909,
      -32'sd74195, 32'sd72033, 32'sd92428, 32'sd3574, 32'sd3554, -32'sd16367},
    '{32'sd67845, 32'sd26505, 32'sd74044, 32'sd42144, 32'sd10382, -32'sd13296,
      32'sd127284, 32'sd15439, -32'sd11102, 32'sd87331, 32'sd6706, 32'sd33212}
  };

  localparam logic signed [31:0] BIAS_ROM [ROM_CLASSES] = '{
    -32'sd37238, -32'sd43753, -32'sd147527, -32'sd70904
  };

  // out-of-table coefficients read as zero
  function automatic logic signed [31:0] weight_at(input int c, input int f);
    logic signed [31:0] w;
    w = '0;
    if (c < ROM_CLASSES && f < ROM_FEATURES) w = WEIGHT_ROM[c][f];
    return w;
  endfunction

  function automatic logic signed [31:0] bias_at(input int c);
    logic signed [31:0] b;
    b = '0;
    if (c < ROM_CLASSES) b = BIAS_ROM[c];
    return b;
  endfunction

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAC_MUL,
    ST_MAC_ADD,
    ST_MAX,
    ST_EXP_INIT,
    ST_EXP_K,
    ST_SER_MUL,
    ST_SER_DIV,
    ST_SER_WAIT,
    ST_EXP_ROUND,
    ST_PROB_START,
    ST_PROB_WAIT
  } state_t;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

endpackage

[hw/rtl/lssc_div.sv]
// Restoring divider, one quotient bit per cycle.
// Uses lssc_pkg for the default dividend width.
module lssc_div import lssc_pkg::*; #(
  parameter int DW = DIV_W,
  parameter int VW = 21
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);
  localparam int CNT_W = $clog2(DW + 1);

  logic [DW-1:0]    quo;
  logic [VW-1:0]    rem;
  logic [VW-1:0]    dvs;
  logic [CNT_W-1:0] cnt;
  logic [VW:0]      shifted;
  logic             fits;

  // one restoring step
  always_comb begin
    shifted = {rem, quo[DW-1]};
    fits    = shifted >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(DW);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (cnt != '0) begin
      quo <= {quo[DW-2:0], fits};
      rem <= fits ? VW'(shifted - {1'b0, dvs}) : shifted[VW-1:0];
    end
  end

  assign quotient = quo;
endmodule

[hw/rtl/lssc_mul.sv]
// Shared signed 33x33 multiplier with a registered product.
// Used for the score MACs and the exp series terms.
module lssc_mul (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] p
);
  always_ff @(posedge clk) begin
    p <= a * b;
  end
endmodule

[hw/rtl/linear_svm_softmax_classifier_unit.sv]
// Top level of the linear classifier with softmax.
// Depends on lssc_pkg, lssc_mul and lssc_div.
//
// Takes one signed Q16.16 feature per beat (start while busy is low) and
// accumulates four saturating Q32.32 class scores. Each feature makes one
// multiply and one add per class on the shared multiplier; busy stays high
// until every class is updated, so the next feature is taken only after
// that. After the last feature of a vector the unit scans for the max,
// forms exp of each difference by ln2 reduction, a 13-term series on the
// shared multiplier and a serial divider, and then divides each exp by the
// sum on the same divider. busy is high throughout. Each result appears
// for a single cycle with result_valid and cannot be stalled; the final
// result of a vector has last_of_run set.
module linear_svm_softmax_classifier_unit import lssc_pkg::*; #(
  parameter int FEATURE_COUNT = FEATURE_COUNT_DEF,
  parameter int CLASS_COUNT   = CLASS_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] feature_value,
  output logic               result_valid,
  output logic [1:0]         class_index,
  output logic [16:0]        probability,
  output logic [1:0]         best_class,
  output logic               last_of_run
);
  localparam int CIW  = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
  localparam int FIW  = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
  localparam int SUMW = 17 + CIW;
  localparam int ACCW = 35;

  state_t state, state_next;

  logic signed [31:0] feat;
  logic [FIW-1:0]     fcount;
  logic [CIW-1:0]     cls;
  logic signed [63:0] score [CLASS_COUNT];
  logic signed [63:0] peak_score;
  logic [CIW-1:0]     best;
  logic [63:0]        x;
  logic [4:0]         k;
  logic [31:0]        r;
  logic [31:0]        term;
  logic signed [ACCW-1:0] acc;
  logic [3:0]         n;
  logic [16:0]        expv [CLASS_COUNT];
  logic [SUMW-1:0]    exp_sum;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic               div_start;
  logic               div_done;
  logic [DIV_W-1:0]   div_dividend, div_quo;
  logic [SUMW-1:0]    div_divisor;

  logic               cls_last, feat_last;
  logic signed [63:0] score_sel, score_base, sat_sum;
  logic signed [64:0] wide_sum;
  logic [63:0]        diff;
  logic [33:0]        acc_pos;
  logic [40:0]        round_sum;
  logic [16:0]        exp_round;

  lssc_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));

  lssc_div #(.DW(DIV_W), .VW(SUMW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .done(div_done), .quotient(div_quo)
  );

  // datapath helpers
  always_comb begin
    cls_last   = cls == CIW'(CLASS_COUNT - 1);
    feat_last  = fcount == FIW'(FEATURE_COUNT - 1);
    score_sel  = score[cls];
    score_base = (fcount == '0) ? 64'(bias_at(int'(cls))) <<< 16 : score_sel;
    wide_sum   = {score_base[63], score_base} + {prod[63], prod[63:0]};
    if (wide_sum[64] != wide_sum[63])
      sat_sum = wide_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    else
      sat_sum = wide_sum[63:0];
    diff      = peak_score - score_sel;
    acc_pos   = acc[ACCW-1] ? '0 : acc[33:0];
    round_sum = 41'(acc_pos) + (41'd1 << (6'(k) + 6'd15));
    exp_round = 17'(round_sum >> (6'(k) + 6'd16));
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:       if (start) state_next = ST_MAC_MUL;
      ST_MAC_MUL:    state_next = ST_MAC_ADD;
      ST_MAC_ADD: begin
        if (!cls_last)      state_next = ST_MAC_MUL;
        else if (feat_last) state_next = ST_MAX;
        else                state_next = ST_IDLE;
      end
      ST_MAX:        if (cls_last) state_next = ST_EXP_INIT;
      ST_EXP_INIT:   state_next = (diff >= EXP_LIMIT) ? ST_EXP_ROUND : ST_EXP_K;
      ST_EXP_K:      if (x < 64'(LN2_Q32)) state_next = ST_SER_MUL;
      ST_SER_MUL:    state_next = ST_SER_DIV;
      ST_SER_DIV:    state_next = ST_SER_WAIT;
      ST_SER_WAIT: begin
        if (div_done) state_next = (n == SER_TERMS) ? ST_EXP_ROUND : ST_SER_MUL;
      end
      ST_EXP_ROUND:  state_next = cls_last ? ST_PROB_START : ST_EXP_INIT;
      ST_PROB_START: begin
        if (exp_sum != '0) state_next = ST_PROB_WAIT;
        else               state_next = cls_last ? ST_IDLE : ST_PROB_START;
      end
      ST_PROB_WAIT: begin
        if (div_done) state_next = cls_last ? ST_IDLE : ST_PROB_START;
      end
      default:       state_next = ST_IDLE;
    endcase
  end

  // unit control
  always_comb begin
    mul_a        = {1'b0, term};
    mul_b        = {1'b0, r};
    div_start    = 1'b0;
    div_dividend = DIV_W'(prod[63:32]);
    div_divisor  = SUMW'(n);
    case (state)
      ST_MAC_MUL: begin
        mul_a = 33'(weight_at(int'(cls), int'(fcount)));
        mul_b = 33'(feat);
      end
      ST_SER_DIV: div_start = 1'b1;
      ST_PROB_START: begin
        div_start    = exp_sum != '0;
        div_dividend = DIV_W'({expv[cls], 16'd0}) + DIV_W'(exp_sum >> 1);
        div_divisor  = exp_sum;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // control counters and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      fcount       <= '0;
      cls          <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        ST_IDLE: if (start) cls <= '0;
        ST_MAC_ADD: begin
          cls <= cls_last ? '0 : cls + 1'b1;
          if (cls_last) fcount <= feat_last ? '0 : fcount + 1'b1;
        end
        ST_MAX, ST_EXP_ROUND: cls <= cls_last ? '0 : cls + 1'b1;
        ST_PROB_START: begin
          if (exp_sum == '0) begin
            result_valid <= 1'b1;
            cls          <= cls + 1'b1;
          end
        end
        ST_PROB_WAIT: begin
          if (div_done) begin
            result_valid <= 1'b1;
            cls          <= cls + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CLASS_COUNT; i++) begin
        score[i] <= '0;
        expv[i]  <= '0;
      end
    end else begin
      case (state)
        ST_IDLE:    if (start) feat <= feature_value;
        ST_MAC_ADD: score[cls] <= sat_sum;
        ST_MAX: begin
          if (cls == '0 || score_sel > peak_score) begin
            peak_score <= score_sel;
            best       <= cls;
          end
          if (cls_last) exp_sum <= '0;
        end
        ST_EXP_INIT: begin
          x <= diff;
          k <= '0;
          if (diff >= EXP_LIMIT) acc <= '0;
        end
        ST_EXP_K: begin
          if (x >= 64'(LN2_Q32)) begin
            x <= x - 64'(LN2_Q32);
            k <= k + 1'b1;
          end else begin
            // first series term is r itself
            r    <= x[31:0];
            term <= x[31:0];
            acc  <= ACCW'(64'd1 << 32) - ACCW'(x[31:0]);
            n    <= 4'd2;
          end
        end
        ST_SER_WAIT: begin
          if (div_done) begin
            term <= div_quo[31:0];
            if (n[0]) acc <= acc - ACCW'(div_quo[31:0]);
            else      acc <= acc + ACCW'(div_quo[31:0]);
            n <= n + 1'b1;
          end
        end
        ST_EXP_ROUND: begin
          expv[cls] <= (acc == '0) ? 17'd0 : exp_round;
          exp_sum   <= exp_sum + SUMW'((acc == '0) ? 17'd0 : exp_round);
        end
        ST_PROB_START: begin
          if (exp_sum == '0) begin
            class_index <= 2'(cls);
            probability <= '0;
            best_class  <= 2'(best);
            last_of_run <= cls_last;
          end
        end
        ST_PROB_WAIT: begin
          if (div_done) begin
            class_index <= 2'(cls);
            probability <= div_quo[16:0];
            best_class  <= 2'(best);
            last_of_run <= cls_last;
          end
        end
        default: ;
      endcase
    end
  end

  assign busy = state != ST_IDLE;
endmodule

[hw/rtl/lssc_checker.sv]
// Port checker for the linear classifier unit, bound to the top level.
// Depends on linear_svm_softmax_classifier_unit_assert.svh.
`include "linear_svm_softmax_classifier_unit_assert.svh"
module lssc_checker #(
  parameter int CLASS_COUNT = 4
) (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        result_valid,
  input logic [1:0]  class_index,
  input logic [16:0] probability,
  input logic        last_of_run
);
  logic last_beat;

  // final beat of a vector
  assign last_beat = result_valid && last_of_run;

  `LSSC_ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy)
  `LSSC_ASSERT_NXT(a_beats_spaced, clk, rst, result_valid, !result_valid)
  `LSSC_ASSERT_IMP(a_prob_range, clk, rst, result_valid, probability <= 17'd65536)
  `LSSC_ASSERT_IMP(a_last_class, clk, rst, last_beat, class_index == 2'(CLASS_COUNT - 1))
  `LSSC_ASSERT_IMP(a_busy_midrun, clk, rst, result_valid && !last_of_run, busy)
endmodule

bind linear_svm_softmax_classifier_unit lssc_checker #(.CLASS_COUNT(CLASS_COUNT))
  u_lssc_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .result_valid(result_valid),
  .class_index(class_index), .probability(probability), .last_of_run(last_of_run)
);

[bench/tb_linear_svm_softmax_classifier_unit.sv]
// Testbench for linear_svm_softmax_classifier_unit: feeds feature vectors,
// predicts the four softmax results per vector and checks each result beat.
// Depends on lssc_pkg and the unit RTL.
module tb_linear_svm_softmax_classifier_unit;
  import lssc_pkg::*;

  localparam int NFEAT = FEATURE_COUNT_DEF;
  localparam int NCLS  = CLASS_COUNT_DEF;
  localparam int RAND_VECTORS = 34;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic signed [31:0] feature_value = '0;
  logic               busy;
  logic               result_valid;
  logic [1:0]         class_index;
  logic [16:0]        probability;
  logic [1:0]         best_class;
  logic               last_of_run;

  linear_svm_softmax_classifier_unit DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .feature_value(feature_value), .result_valid(result_valid),
    .class_index(class_index), .probability(probability),
    .best_class(best_class), .last_of_run(last_of_run)
  );

  always #5 clk = ~clk;

  typedef struct {
    logic [1:0]  cls;
    logic [16:0] prob;
    logic [1:0]  best;
    logic        last;
  } class_result_t;

  // directed row: feature plus, on a vector's last feature, a typed outcome
  typedef struct {
    logic signed [31:0] feat;
    bit                 typed;
    logic [1:0]         best;
    logic [16:0]        prob [NCLS];
  } feature_row_t;

  class_result_t pending_results[$];
  longint        score [NCLS];
  int            feat_idx;
  int            mismatches;
  bit            idle_ok;

  // exp(-x) for Q32.32 x >= 0, Q1.16 result
  function automatic logic [16:0] exp_q16(logic [63:0] x);
    logic [63:0]        k, r, term;
    logic [127:0]       prod;
    logic signed [63:0] acc;
    int                 s;
    if (x >= (64'd16 << 32)) return '0;
    k = x / {32'd0, LN2_Q32};
    r = x - k * {32'd0, LN2_Q32};
    term = 64'd1 << 32;
    acc = 64'sd1 <<< 32;
    for (int n = 1; n <= 13; n++) begin
      prod = {64'd0, term} * {64'd0, r};
      term = prod[95:32] / n;
      if (n % 2 == 1) acc = acc - $signed(term);
      else acc = acc + $signed(term);
    end
    if (acc < 0) acc = 0;
    s = 16 + int'(k);
    return 17'((64'(acc) + (64'd1 << (s - 1))) >> s);
  endfunction

  // accumulate one feature; on the last one produce the softmax beats
  task automatic classify_feature(input logic signed [31:0] feat, output bit done,
                                  output class_result_t res [NCLS]);
    logic signed [64:0] t;
    logic [63:0]        sum, p;
    logic [16:0]        ex [NCLS];
    int                 best;
    done = 1'b0;
    if (feat_idx == 0)
      for (int c = 0; c < NCLS; c++) score[c] = longint'(bias_at(c)) * 65536;
    for (int c = 0; c < NCLS; c++) begin
      t = 65'(score[c]) + 65'(longint'(weight_at(c, feat_idx)) * longint'(feat));
      if (t > 65'sh0_7FFF_FFFF_FFFF_FFFF) score[c] = 64'sh7FFF_FFFF_FFFF_FFFF;
      else if (t < -65'sh0_8000_0000_0000_0000) score[c] = 64'sh8000_0000_0000_0000;
      else score[c] = t[63:0];
    end
    feat_idx++;
    if (feat_idx < NFEAT) return;
    feat_idx = 0;
    done = 1'b1;
    best = 0;
    for (int c = 1; c < NCLS; c++) if (score[c] > score[best]) best = c;
    sum = '0;
    for (int c = 0; c < NCLS; c++) begin
      ex[c] = exp_q16(64'(score[best]) - 64'(score[c]));
      sum += ex[c];
    end
    for (int c = 0; c < NCLS; c++) begin
      p = (sum == 0) ? '0 : (({47'd0, ex[c]} << 16) + sum / 2) / sum;
      res[c].cls  = 2'(c);
      res[c].prob = p[16:0];
      res[c].best = 2'(best);
      res[c].last = (c == NCLS - 1);
    end
  endtask

  // one feature beat: hold start until the unit takes it
  task automatic send_feature(input feature_row_t row);
    bit            done;
    class_result_t res [NCLS];
    start <= 1'b1;
    feature_value <= row.feat;
    do @(posedge clk); while (busy);
    classify_feature(row.feat, done, res);
    if (done)
      for (int c = 0; c < NCLS; c++) begin
        if (row.typed) begin
          res[c].prob = row.prob[c];
          res[c].best = row.best;
        end
        pending_results.push_back(res[c]);
      end
    if (idle_ok && $urandom_range(99) < 14) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  function automatic logic signed [31:0] random_feature(int mode);
    case (mode)
      0:       return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      1:       return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
      2:       return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // result checker; the unit cannot be stalled, so every valid cycle is a beat
  always @(posedge clk) begin
    class_result_t want;
    if (!rst && result_valid) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: class %0d", class_index);
      end else begin
        want = pending_results.pop_front();
        if (class_index !== want.cls || probability !== want.prob ||
            best_class !== want.best || last_of_run !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp cls %0d prob %0d best %0d last %0d, got %0d %0d %0d %0d",
                     want.cls, want.prob, want.best, want.last,
                     class_index, probability, best_class, last_of_run);
        end
      end
    end
  end

  initial begin
    #30000000;
    $display("tb_linear_svm_softmax_classifier_unit: FAIL");
    $finish;
  end

  initial begin
    feature_row_t rows[$];
    feature_row_t row;
    int           mode;
    int           waited;
    feat_idx = 0;
    mismatches = 0;
    idle_ok = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // all-max vector: class 3 dominates by far; all-min vector: class 0 does
    for (int v = 0; v < 2; v++)
      for (int f = 0; f < NFEAT; f++) begin
        row.feat  = (v == 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        row.typed = (f == NFEAT - 1);
        row.best  = (v == 0) ? 2'd3 : 2'd0;
        for (int c = 0; c < NCLS; c++) row.prob[c] = (c == row.best) ? 17'd65536 : 17'd0;
        rows.push_back(row);
      end
    foreach (rows[i]) send_feature(rows[i]);

    // random vectors, mostly small features so the softmax stays soft
    row.typed = 1'b0;
    for (int v = 0; v < RAND_VECTORS; v++) begin
      idle_ok = !(v >= 12 && v < 20);
      mode = $urandom_range(99);
      mode = (mode < 55) ? 0 : (mode < 75) ? 1 : (mode < 85) ? 2 : 3;
      if (v == 22) begin
        // hold off until the unit has drained
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      for (int f = 0; f < NFEAT; f++) begin
        row.feat = random_feature(($urandom_range(9) == 0) ? 3 : mode);
        send_feature(row);
      end
    end
    start <= 1'b0;

    waited = 0;
    while (pending_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb_linear_svm_softmax_classifier_unit: PASS");
    end else begin
      $display("tb_linear_svm_softmax_classifier_unit: FAIL");
    end
    $finish;
  end
endmodule
